### rtl/lnvt_pkg.sv
// Package for the lane nearest vehicle tracker.
// Holds sizes, command codes and the entry type shared by all modules.
package lnvt_pkg;
  localparam int unsigned MaxVehicles = 64;
  localparam int unsigned IdW    = $clog2(MaxVehicles);
  localparam int unsigned SW     = 21;
  localparam int unsigned DW     = 14;
  localparam int unsigned VW     = 15;
  localparam int unsigned LaneW  = 4;
  localparam int unsigned SpdW   = 15;
  localparam int unsigned LwW    = 13;
  localparam int unsigned CmdW   = 2;
  localparam logic [LwW-1:0] LaneWidthReset = 13'd1024;
  localparam logic [LaneW-1:0] LaneMax = 4'd15;

  localparam logic [CmdW-1:0] CmdUpdate   = 2'd0;
  localparam logic [CmdW-1:0] CmdAhead    = 2'd1;
  localparam logic [CmdW-1:0] CmdBehind   = 2'd2;
  localparam logic [CmdW-1:0] CmdReserved = 2'd3;

  typedef struct packed {
    logic             valid;
    logic [LaneW-1:0] lane;
    logic [SW-1:0]    s;
    logic [SpdW-1:0]  speed;
  } entry_t;

  typedef struct packed {
    logic [CmdW-1:0]  command;
    logic [IdW-1:0]   vehicle_id;
    logic [SW-1:0]    position_s;
    logic [DW-1:0]    position_d;
    logic [VW-1:0]    velocity_x;
    logic [VW-1:0]    velocity_y;
    logic [LaneW-1:0] query_lane;
  } in_item_t;

  typedef struct packed {
    logic             found;
    logic [IdW-1:0]   result_id;
    logic [SW-1:0]    result_s;
    logic [LaneW-1:0] result_lane;
    logic [SpdW-1:0]  result_speed;
  } out_item_t;
endpackage

### rtl/lnvt_if.sv
// Valid/ready channel interface carrying one payload struct.
// Depends on lnvt_pkg for the payload types.
interface lnvt_in_if;
  logic                  valid;
  logic                  ready;
  lnvt_pkg::in_item_t    data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lnvt_out_if;
  logic                  valid;
  logic                  ready;
  lnvt_pkg::out_item_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/lnvt_cell.sv
// One table cell: holds a vehicle entry and passes the rotating ring word on.
// Depends on lnvt_pkg.
module lnvt_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  shift_i,
  input  logic                  load_i,
  input  lnvt_pkg::entry_t      load_entry_i,
  input  lnvt_pkg::entry_t      prev_i,
  output lnvt_pkg::entry_t      entry_o
);
  import lnvt_pkg::*;
  logic             valid_q;
  logic [LaneW-1:0] lane_q;
  logic [SW-1:0]    s_q;
  logic [SpdW-1:0]  speed_q;

  // The valid bit resets; the payload is undefined until written.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= load_entry_i.valid;
    end else if (shift_i) begin
      valid_q <= prev_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      lane_q  <= load_entry_i.lane;
      s_q     <= load_entry_i.s;
      speed_q <= load_entry_i.speed;
    end else if (shift_i) begin
      lane_q  <= prev_i.lane;
      s_q     <= prev_i.s;
      speed_q <= prev_i.speed;
    end
  end

  assign entry_o = {valid_q, lane_q, s_q, speed_q};
endmodule

### rtl/lnvt_ring.sv
// Ring of table cells. The table rotates one place per shift; cell 0 always
// holds the entry whose id equals the rotation count. Depends on lnvt_cell.
module lnvt_ring (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  shift_i,
  input  logic                  load_i,
  input  lnvt_pkg::entry_t      load_entry_i,
  output lnvt_pkg::entry_t      head_o
);
  import lnvt_pkg::*;
  entry_t chain [MaxVehicles];

  // A load takes the place of the head entry as it wraps into the last cell.
  for (genvar g = 0; g < MaxVehicles; g++) begin : g_cell
    lnvt_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .shift_i      (shift_i),
      .load_i       (load_i && (g == MaxVehicles - 1)),
      .load_entry_i (load_entry_i),
      .prev_i       (chain[(g + 1) % MaxVehicles]),
      .entry_o      (chain[g])
    );
  end

  assign head_o = chain[0];
endmodule

### rtl/lane_nearest_vehicle_tracker.sv
// Top level of the lane nearest vehicle tracker.
// Flow: a query rotates the ring once through every entry, then presents
// the registered result from the output state; an update first runs the
// lane division and square root, then rotates the ring once around.
// One item at a time, taken only when idle; a reserved command is ignored;
// a query waits in the output state while an earlier result stalls.
// Reset: all entries invalid, lane width 1024; no clearing pass.
module lane_nearest_vehicle_tracker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [lnvt_pkg::LwW-1:0] cfg_wdata_i,
  lnvt_in_if.sink              in_if,
  lnvt_out_if.source           out_if
);
  import lnvt_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StPrep = 3'd1;
  localparam logic [2:0] StRot  = 3'd2;
  localparam logic [2:0] StOut  = 3'd3;

  localparam int unsigned CntW = IdW + 1;
  localparam int unsigned SqW  = 2 * VW;

  logic [2:0]        state_q, state_d;
  logic [LwW-1:0]    lane_width_q;
  in_item_t          item_q;
  logic [CntW-1:0]   cnt_q;
  logic [4:0]        step_q;
  // Restoring lane divider and bit-pair square root.
  logic [DW-1:0]     rem_q;
  logic [4:0]        quo_q;
  logic [SqW-1:0]    sq_q;
  logic [SqW-1:0]    rad_q;
  logic [SqW-1:0]    root_q;
  logic              neg_q;
  logic              have_q;
  logic [IdW-1:0]    best_id_q;
  logic [SW-1:0]     best_s_q;
  logic [SpdW-1:0]   best_spd_q;
  out_item_t         out_q;
  logic              out_valid_q;

  entry_t            head;
  entry_t            load_entry;
  logic              shift, load;
  logic [IdW-1:0]    cur_id;
  logic              hit, better;

  lnvt_ring u_ring (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .shift_i      (shift),
    .load_i       (load),
    .load_entry_i (load_entry),
    .head_o       (head)
  );

  // Ring rotation count, modulo the table size, tells which id sits at cell 0.
  logic [IdW-1:0] rot_q;
  assign cur_id = rot_q;

  assign in_if.ready = (state_q == StIdle);
  wire in_acc = in_if.valid && in_if.ready;
  wire is_upd = (item_q.command == CmdUpdate);

  // The step of the divider: quotient bits from 4 down to 0, lane saturated.
  logic [DW+4:0] div_sub;
  assign div_sub = {{5{1'b0}}, {1'b0}, lane_width_q} << (3'd4 - step_q[2:0]);

  // Square-root step indexed from the top pair (pair 14 at step 1).
  logic [SqW-1:0] sqrt_bit_s;
  logic [SqW:0]   sqrt_trial_s;
  logic [3:0]     pair;
  assign pair = 4'(5'd15 - step_q);
  assign sqrt_bit_s   = {{(SqW-2){1'b0}}, 2'b01} << {pair, 1'b0};
  assign sqrt_trial_s = {1'b0, root_q} + {1'b0, sqrt_bit_s};

  assign hit = head.valid && (head.lane == item_q.query_lane) &&
               ((item_q.command == CmdAhead) ? (head.s > item_q.position_s)
                                             : (head.s < item_q.position_s));
  assign better = !have_q ||
                  ((item_q.command == CmdAhead) ? (best_s_q > head.s)
                                                : (best_s_q < head.s));

  always_comb begin
    load_entry.valid = !neg_q;
    load_entry.lane  = neg_q ? LaneMax : ((quo_q > 5'd15) ? LaneMax : quo_q[LaneW-1:0]);
    load_entry.s     = item_q.position_s;
    load_entry.speed = root_q[SpdW-1:0];
  end

  assign shift = (state_q == StRot);
  assign load  = (state_q == StRot) && is_upd && (cur_id == item_q.vehicle_id);

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (in_acc) begin
        if (in_if.data.command == CmdUpdate) state_d = StPrep;
        else if (in_if.data.command inside {CmdAhead, CmdBehind}) state_d = StRot;
      end
      StPrep: if (step_q == 5'd15) state_d = StRot;
      StRot:  if (cnt_q == CntW'(MaxVehicles - 1)) state_d = is_upd ? StIdle : StOut;
      StOut:  if (!out_valid_q) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      lane_width_q <= LaneWidthReset;
      out_valid_q  <= 1'b0;
      rot_q        <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) lane_width_q <= cfg_wdata_i;
      if (shift) rot_q <= rot_q + 1'b1;
      if (state_q == StOut && !out_valid_q) out_valid_q <= 1'b1;
      else if (out_if.ready) out_valid_q <= 1'b0;
    end
  end

  // Datapath; a load writes the entry at the head as it moves on to the last
  // cell, so the table keeps its order around the ring.
  logic signed [SqW-1:0] vx2, vy2;
  assign vx2 = SqW'($signed(in_if.data.velocity_x) * $signed(in_if.data.velocity_x));
  assign vy2 = SqW'($signed(in_if.data.velocity_y) * $signed(in_if.data.velocity_y));

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q  <= in_if.data;
      cnt_q   <= '0;
      step_q  <= '0;
      have_q  <= 1'b0;
      neg_q   <= in_if.data.position_d[DW-1];
      rem_q   <= in_if.data.position_d;
      quo_q   <= '0;
      sq_q    <= vx2 + vy2;
      root_q  <= '0;
      best_id_q  <= '0;
      best_s_q   <= '0;
      best_spd_q <= '0;
    end else if (state_q == StPrep) begin
      step_q <= step_q + 5'd1;
      if (step_q < 5'd5) begin
        if ({5'd0, rem_q} >= div_sub) begin
          rem_q <= rem_q - div_sub[DW-1:0];
          quo_q <= quo_q | (5'd1 << (3'd4 - step_q[2:0]));
        end
      end
      // Square root: bit pairs from the top, one per cycle over 15 pairs.
      if (step_q >= 5'd1) begin
        if ({1'b0, sq_q} >= sqrt_trial_s) begin
          sq_q   <= sq_q - sqrt_trial_s[SqW-1:0];
          root_q <= (root_q >> 1) + sqrt_bit_s;
        end else begin
          root_q <= root_q >> 1;
        end
      end
    end else if (state_q == StRot) begin
      cnt_q <= cnt_q + 1'b1;
      if (!is_upd && hit && better) begin
        have_q     <= 1'b1;
        best_id_q  <= cur_id;
        best_s_q   <= head.s;
        best_spd_q <= head.speed;
      end
    end
    if (state_q == StOut && !out_valid_q) begin
      out_q.found        <= have_q;
      out_q.result_id    <= best_id_q;
      out_q.result_s     <= best_s_q;
      out_q.result_lane  <= item_q.query_lane;
      out_q.result_speed <= best_spd_q;
    end
  end

  assign out_if.valid = out_valid_q;
  assign out_if.data  = out_q;

  // Not found means id, position and speed are zero; the lane echoes the query.
  a_nf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.data.found |-> out_if.data.result_id == '0 &&
    out_if.data.result_s == '0 && out_if.data.result_speed == '0)
    else $error("not-found result carries data");
  // No input is taken while the ring rotates.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StRot |-> !in_if.ready) else $error("ready during scan");
  // A scan starts with the ring at its home position.
  a_home: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StIdle |-> rot_q == '0) else $error("ring not at home");
endmodule
